// ===== hw/rtl/asgr_pkg.sv =====
`default_nettype none
package asgr_pkg;

   localparam logic [1:0] MODE_PLAIN  = 2'd0;
   localparam logic [1:0] MODE_ESC    = 2'd1;
   localparam logic [1:0] MODE_PARAMS = 2'd2;

   localparam logic [20:0] CH_ESC  = 21'h1B;
   localparam logic [20:0] CH_LBR  = 21'h5B;
   localparam logic [20:0] CH_M    = 21'h6D;
   localparam logic [20:0] CH_SEMI = 21'h3B;
   localparam logic [20:0] CH_PLUS = 21'h2B;
   localparam logic [20:0] CH_MINUS = 21'h2D;

   // code word: bit 9 = negative, bits 8:0 = magnitude
   localparam logic [9:0] CODE_NEG = 10'h200;

   localparam int FifoDepth = 2;

   // front to back command
   typedef struct packed {
      logic        is_char;   // emit character
      logic [20:0] char_code;
      logic        clear;     // reset attributes first
      logic        has_code;  // a parameter finished
      logic [9:0]  code;
      logic        is_end;    // 'm' or '[': flush pending
   } cmd_type;

   typedef struct packed {
      logic [20:0] char_code;
      logic        bold;
      logic [23:0] fg;
      logic        fg_set;
      logic [23:0] bg;
      logic        bg_set;
   } rsp_type;

   function automatic logic [7:0] cube_level(input logic [2:0] v);
      cube_level = (v == 3'd0) ? 8'd0 : 8'(({5'd0, v} * 8'd40) + 8'd55);
   endfunction

   function automatic logic [23:0] palette(input logic [7:0] n);
      logic [7:0] k;
      logic [7:0] rem;
      logic [2:0] r;
      logic [2:0] g;
      logic [2:0] b;
      logic [7:0] y;
      logic [7:0] hi;
      logic [7:0] lo;
      k = n - 8'd16;
      // base-36 digit by compare and subtract
      if (k >= 8'd180) begin
         r = 3'd5; rem = k - 8'd180;
      end else if (k >= 8'd144) begin
         r = 3'd4; rem = k - 8'd144;
      end else if (k >= 8'd108) begin
         r = 3'd3; rem = k - 8'd108;
      end else if (k >= 8'd72) begin
         r = 3'd2; rem = k - 8'd72;
      end else if (k >= 8'd36) begin
         r = 3'd1; rem = k - 8'd36;
      end else begin
         r = 3'd0; rem = k;
      end
      // base-6 digits of the remainder
      if (rem >= 8'd30) begin
         g = 3'd5; b = 3'(rem - 8'd30);
      end else if (rem >= 8'd24) begin
         g = 3'd4; b = 3'(rem - 8'd24);
      end else if (rem >= 8'd18) begin
         g = 3'd3; b = 3'(rem - 8'd18);
      end else if (rem >= 8'd12) begin
         g = 3'd2; b = 3'(rem - 8'd12);
      end else if (rem >= 8'd6) begin
         g = 3'd1; b = 3'(rem - 8'd6);
      end else begin
         g = 3'd0; b = 3'(rem);
      end
      y = 8'(((n - 8'd232) * 8'd10) + 8'd8);
      hi = n[3] ? 8'd255 : 8'd128;
      lo = (n == 8'd7) ? 8'd192 : ((n == 8'd8) ? 8'd128 : 8'd0);
      if (n < 8'd16) begin
         if (n == 8'd7 || n == 8'd8) palette = {lo, lo, lo};
         else palette = {n[0] ? hi : 8'd0, n[1] ? hi : 8'd0, n[2] ? hi : 8'd0};
      end else if (n < 8'd232) begin
         palette = {cube_level(r), cube_level(g), cube_level(b)};
      end else begin
         palette = {y, y, y};
      end
   endfunction

   function automatic logic [7:0] byte_of(input logic [9:0] w);
      if (w[9]) byte_of = 8'd0;
      else if (w[8]) byte_of = 8'd255;
      else byte_of = w[7:0];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/asgr_front.sv =====
`default_nettype none
module asgr_front
   import asgr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [20:0] in_char,
   input  wire logic        in_first,
   output logic             cmd_valid,
   input  wire logic        cmd_ready,
   output cmd_type          cmd
);

   logic [1:0] mode_ff, mode_in;
   logic [9:0] num_ff, num_in;
   logic       dig_ff, dig_in;
   logic       stop_ff, stop_in;
   logic       neg_ff, neg_in;
   logic       sgn_ff, sgn_in;

   logic [1:0] md;
   logic       dg, st, ng, sg;
   logic [9:0] nv;
   logic [13:0] prod;
   logic [8:0] mag;
   logic       is_digit, is_space;
   logic       emit_cmd, fire;

   // no beat is taken while reset is high
   assign in_ready = cmd_ready && !reset;
   assign fire     = in_valid && in_ready;

   // classify one character against parser state
   always_comb begin
      md = in_first ? MODE_PLAIN : mode_ff;
      nv = in_first ? 10'd0 : num_ff;
      dg = in_first ? 1'b0 : dig_ff;
      st = in_first ? 1'b0 : stop_ff;
      ng = in_first ? 1'b0 : neg_ff;
      sg = in_first ? 1'b0 : sgn_ff;
      mode_in = md; num_in = nv; dig_in = dg; stop_in = st; neg_in = ng; sgn_in = sg;
      is_digit = (in_char >= 21'h30) && (in_char <= 21'h39);
      is_space = (in_char == 21'h20) || ((in_char >= 21'h09) && (in_char <= 21'h0D));
      prod = {4'd0, nv} * 14'd10 + {10'd0, in_char[3:0]};
      mag = (nv > 10'd511) ? 9'h1FF : nv[8:0];
      cmd = '0;
      cmd.char_code = in_char;
      cmd.clear = in_first;
      cmd.code = (ng && mag != 9'd0) ? (CODE_NEG | {1'b0, mag}) : {1'b0, mag};
      emit_cmd = in_first;
      if (md == MODE_PARAMS) begin
         if (in_char == CH_M || in_char == CH_SEMI) begin
            cmd.has_code = dg;
            cmd.is_end = (in_char == CH_M);
            emit_cmd = 1'b1;
            num_in = '0; dig_in = 1'b0; stop_in = 1'b0; neg_in = 1'b0; sgn_in = 1'b0;
            if (in_char == CH_M) mode_in = MODE_PLAIN;
         end else if (!st) begin
            if (is_digit) begin
               dig_in = 1'b1;
               num_in = (prod > 14'd1023) ? 10'd1023 : prod[9:0];
            end else if (dg) begin
               stop_in = 1'b1;
            end else if (is_space && !sg) begin
               stop_in = 1'b0;
            end else if ((in_char == CH_PLUS || in_char == CH_MINUS) && !sg) begin
               sgn_in = 1'b1;
               neg_in = (in_char == CH_MINUS);
            end else begin
               stop_in = 1'b1;
            end
         end
      end else if (md == MODE_ESC && in_char == CH_LBR) begin
         mode_in = MODE_PARAMS;
         num_in = '0; dig_in = 1'b0; stop_in = 1'b0; neg_in = 1'b0; sgn_in = 1'b0;
         cmd.is_end = 1'b1;   // start of sequence flushes any pending parameters
         emit_cmd = 1'b1;
      end else if (in_char == CH_ESC) begin
         mode_in = MODE_ESC;
      end else begin
         mode_in = MODE_PLAIN;
         cmd.is_char = 1'b1;
         emit_cmd = 1'b1;
      end
      cmd_valid = in_valid && emit_cmd;
   end

   // parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         num_ff <= '0; dig_ff <= 1'b0; stop_ff <= 1'b0; neg_ff <= 1'b0; sgn_ff <= 1'b0;
      end else if (fire) begin
         mode_ff <= mode_in;
         num_ff <= num_in; dig_ff <= dig_in; stop_ff <= stop_in;
         neg_ff <= neg_in; sgn_ff <= sgn_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/asgr_fifo.sv =====
`default_nettype none
module asgr_fifo
   import asgr_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic wr_valid,
   output logic      wr_ready,
   input  cmd_type   wr_data,
   output logic      rd_valid,
   input  wire logic rd_ready,
   output cmd_type   rd_data
);

   cmd_type    mem_ff [FifoDepth];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign wr_ready = (cnt_ff != 2'(FifoDepth));
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem_ff[rp_ff];

   // two-entry queue
   always_ff @(posedge clock) begin
      if (wr_valid && wr_ready) mem_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (wr_valid && wr_ready) wp_ff <= ~wp_ff;
         if (rd_valid && rd_ready) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/asgr_back.sv =====
`default_nettype none
module asgr_back
   import asgr_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic cmd_valid,
   output logic      cmd_ready,
   input  cmd_type   cmd,
   output logic      out_valid,
   input  wire logic out_ready,
   output rsp_type   out_data
);

   logic        bold_ff, bold_in;
   logic [23:0] fg_ff, fg_in, bg_ff, bg_in;
   logic        fgv_ff, fgv_in, bgv_ff, bgv_in;
   logic [2:0]  pc_ff, pc_in;
   logic [9:0]  p0_ff, p1_ff, p2_ff, p3_ff;
   logic [9:0]  p0_in, p1_in, p2_in, p3_in;
   logic        ov_ff;
   rsp_type     od_ff;
   logic        fire;
   logic        isfg;

   assign out_valid = ov_ff;
   assign out_data  = od_ff;
   assign cmd_ready = !ov_ff || out_ready;
   assign fire      = cmd_valid && cmd_ready;

   // one plain code against the attribute set
   function automatic void basic(input logic [9:0] w, input logic ext,
                                 inout logic b, inout logic [23:0] f, inout logic fv,
                                 inout logic [23:0] g, inout logic gv,
                                 inout logic [2:0] pc, inout logic [9:0] p0);
      if (!w[9]) begin
         if (w == 10'd0) begin
            b = 1'b0; f = '0; fv = 1'b0; g = '0; gv = 1'b0;
         end else if (w == 10'd1) begin
            b = 1'b1;
         end else if (w == 10'd38 || w == 10'd48) begin
            if (ext) begin p0 = w; pc = 3'd1; end
         end else if (w >= 10'd30 && w <= 10'd37) begin
            f = palette(8'(w - 10'd30)); fv = 1'b1;
         end else if (w >= 10'd40 && w <= 10'd47) begin
            g = palette(8'(w - 10'd40)); gv = 1'b1;
         end
      end
   endfunction

   // execute one command
   always_comb begin
      bold_in = bold_ff; fg_in = fg_ff; fgv_in = fgv_ff; bg_in = bg_ff; bgv_in = bgv_ff;
      pc_in = pc_ff; p0_in = p0_ff; p1_in = p1_ff; p2_in = p2_ff; p3_in = p3_ff;
      isfg = 1'b0;
      if (cmd.clear) begin
         bold_in = 1'b0; fg_in = '0; fgv_in = 1'b0; bg_in = '0; bgv_in = 1'b0;
         pc_in = '0;
      end
      if (cmd.has_code) begin
         isfg = (p0_in == 10'd38);
         if (pc_in == 3'd0) begin
            basic(cmd.code, 1'b1, bold_in, fg_in, fgv_in, bg_in, bgv_in, pc_in, p0_in);
         end else if (pc_in == 3'd1) begin
            if (cmd.code == 10'd5 || cmd.code == 10'd2) begin
               p1_in = cmd.code; pc_in = 3'd2;
            end else begin
               pc_in = 3'd0;
               basic(cmd.code, 1'b1, bold_in, fg_in, fgv_in, bg_in, bgv_in, pc_in, p0_in);
            end
         end else if (p1_in == 10'd5) begin
            if (isfg) begin fg_in = palette(byte_of(cmd.code)); fgv_in = 1'b1; end
            else begin bg_in = palette(byte_of(cmd.code)); bgv_in = 1'b1; end
            pc_in = 3'd0;
         end else if (pc_in == 3'd2) begin
            p2_in = cmd.code; pc_in = 3'd3;
         end else if (pc_in == 3'd3) begin
            p3_in = cmd.code; pc_in = 3'd4;
         end else begin
            if (isfg) begin
               fg_in = {byte_of(p2_in), byte_of(p3_in), byte_of(cmd.code)}; fgv_in = 1'b1;
            end else begin
               bg_in = {byte_of(p2_in), byte_of(p3_in), byte_of(cmd.code)}; bgv_in = 1'b1;
            end
            pc_in = 3'd0;
         end
      end
      if (cmd.is_end) begin
         if (pc_in > 3'd1)
            basic(p1_in, 1'b0, bold_in, fg_in, fgv_in, bg_in, bgv_in, pc_in, p0_in);
         if (pc_in > 3'd2)
            basic(p2_in, 1'b0, bold_in, fg_in, fgv_in, bg_in, bgv_in, pc_in, p0_in);
         if (pc_in > 3'd3)
            basic(p3_in, 1'b0, bold_in, fg_in, fgv_in, bg_in, bgv_in, pc_in, p0_in);
         pc_in = 3'd0;
      end
   end

   // attribute registers and output beat
   always_ff @(posedge clock) begin
      if (fire) begin
         p0_ff <= p0_in; p1_ff <= p1_in; p2_ff <= p2_in; p3_ff <= p3_in;
      end
      if (fire && cmd.is_char)
         od_ff <= '{char_code: cmd.char_code, bold: bold_in, fg: fg_in, fg_set: fgv_in,
                    bg: bg_in, bg_set: bgv_in};
      if (reset) begin
         bold_ff <= 1'b0; fgv_ff <= 1'b0; bgv_ff <= 1'b0; pc_ff <= '0; ov_ff <= 1'b0;
         fg_ff <= '0; bg_ff <= '0;
      end else begin
         if (fire) begin
            bold_ff <= bold_in; fgv_ff <= fgv_in; bgv_ff <= bgv_in; pc_ff <= pc_in;
            fg_ff <= fg_in; bg_ff <= bg_in;
         end
         if (fire) ov_ff <= cmd.is_char;
         else if (out_ready) ov_ff <= 1'b0;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/ansi_sgr_color_parser_top.sv =====
// ANSI SGR colour parser.
// Input stream (req_): one character per beat, tdata = char_code[20:0],
// tuser = first (starts a new string and clears all attributes and parser
// state before the character is handled).
// Output stream (rsp_): one beat per character outside an escape,
// carrying the character with bold, foreground and background RGB and set flags.
// Escape characters, parameters and 'm' produce no output beat.
// Throughput: one input beat per cycle when the output is taken.
// The command is written into the two-entry queue when it is accepted, and the
// back executor then registers its beat in the output register that drives rsp_.
// The front parses digits and separators; the back applies codes and holds
// attributes; the queue lets the two stall on their own.
// When rsp_tready is low the output register holds its beat and the queue
// fills; req_tready drops once the queue is full.
// Reset (synchronous, active high) clears parser and attributes; no item is
// accepted during reset.
`default_nettype none
module ansi_sgr_color_parser_top
   import asgr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // char_code[20:0], zero pad
   input  wire logic        req_tuser,   // first
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // char_code, bold, fg r g b, fg_set, bg r g b, bg_set
   output logic             rsp_tuser    // unused, zero
);

   logic    f_valid, f_ready, q_valid, q_ready;
   cmd_type f_cmd, q_cmd;
   rsp_type r;

   asgr_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_char(req_tdata[20:0]), .in_first(req_tuser),
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
   );

   asgr_fifo u_fifo (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
      .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
   );

   asgr_back u_back (
      .clock, .reset,
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(r)
   );

   // pack result beat
   assign rsp_tdata = {r.bg_set, r.bg[7:0], r.bg[15:8], r.bg[23:16],
                       r.fg_set, r.fg[7:0], r.fg[15:8], r.fg[23:16], r.bold, r.char_code};
   assign rsp_tuser = 1'b0;

`ifndef SYNTHESIS
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");
   a_q_flow: assert property (@(posedge clock) disable iff (reset)
      !q_valid |-> !(q_valid && q_ready))
      else $error("queue read while empty");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !f_ready |-> !req_tready)
      else $error("input taken while queue full");
`endif

endmodule
`default_nettype wire
